@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Property checked at every clock edge, reset included.
`define CHK_RAW(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ design/sha256_pkg.sv @@
// Package for the SHA-256 message hasher: constants and round functions.
// No dependencies.
package sha256_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenBits = 61;

  localparam logic [255:0] INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98;   6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;   6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;   6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;   6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;   6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

@@ design/sha256_message_hasher.sv @@
// SHA-256 message hasher: one byte per request, eight digest words out.
// A byte that does not fill a block is taken while idle; a byte that fills
// one keeps the input closed through the 64 rounds and the feed-forward.
// A final request pads one byte per cycle and compresses one or two blocks before the
// first digest word shows; the hasher is sequential and takes no byte while busy.
// Reset (synchronous, rst high) loads the initial hash and clears all counters.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        no_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a request
  localparam logic [2:0] S_PAD   = 3'd1;  // write one padding byte per cycle
  localparam logic [2:0] S_ROUND = 3'd2;  // one compression round per cycle
  localparam logic [2:0] S_ADD   = 3'd3;  // feed-forward into the hash words
  localparam logic [2:0] S_OUT   = 3'd4;  // present the digest words

  localparam logic [sha256_pkg::LenBits-1:0] LenOne =
    {{(sha256_pkg::LenBits-1){1'b0}}, 1'b1};

  logic [2:0]  state;
  logic [31:0] hash [8];
  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic [sha256_pkg::LenBits-1:0] len;
  logic        pad_active;   // the current request ended the message
  logic        marker_done;  // the 0x80 marker has been written
  logic        len_go;       // bytes 56..63 of this block carry the length
  logic [2:0]  oidx;

  // Padding byte source. After the marker come zeros, and once byte 55 of a
  // block has been written the eight length bytes follow, most significant first.
  logic [63:0] bit_len;
  logic [5:0]  len_shift;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic        take_byte;
  logic        wr_en;
  logic [7:0]  wr_byte;

  assign bit_len   = {len, 3'b000};
  assign len_shift = {~pos[2:0], 3'b000};
  assign len_byte  = 8'(bit_len >> len_shift);

  always_comb begin
    priority if (!marker_done) begin
      pad_byte = 8'h80;
    end else if (len_go) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // A byte enters the block either from an accepted request or from padding.
  assign take_byte = in_valid && !no_byte;
  assign wr_en     = ((state == S_IDLE) && take_byte) || (state == S_PAD);
  assign wr_byte   = (state == S_PAD) ? pad_byte : data_byte;

  // Shared round unit with rolling 16-word message schedule.
  logic [31:0] wi, s0, s1, t1, t2, w2, w7, w15;
  assign w2  = w[rnd[3:0] - 4'd2];
  assign w7  = w[rnd[3:0] - 4'd7];
  assign w15 = w[rnd[3:0] - 4'd15];
  assign s1  = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
  assign s0  = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
  assign wi  = (rnd < 6'd16) ? w[rnd[3:0]] : s1 + w7 + s0 + w[rnd[3:0]];
  assign t1  = v[7] + (sha256_pkg::rotr(v[4], 6) ^ sha256_pkg::rotr(v[4], 11)
             ^ sha256_pkg::rotr(v[4], 25)) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
             + sha256_pkg::round_k(rnd) + wi;
  assign t2  = (sha256_pkg::rotr(v[0], 2) ^ sha256_pkg::rotr(v[0], 13)
             ^ sha256_pkg::rotr(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // The input is open only while idle; the digest is shown only in S_OUT, so
  // a waiting digest holds off further requests.
  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign digest_word = hash[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      len         <= '0;
      rnd         <= '0;
      oidx        <= '0;
      pad_active  <= 1'b0;
      marker_done <= 1'b0;
      len_go      <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash[i] <= sha256_pkg::INIT_HASH[32*(7-i) +: 32];
      end
    end else begin
      // Bytes are packed big-endian into the schedule words.
      if (wr_en) begin
        w[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= wr_byte;
        pos <= pos + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            // A byte-less request that does not end the message changes nothing.
            if (!no_byte) len <= len + LenOne;
            pad_active  <= end_of_message;
            marker_done <= 1'b0;
            len_go      <= 1'b0;
            if (take_byte && pos == 6'd63) begin
              for (int i = 0; i < 8; i++) v[i] <= hash[i];
              rnd   <= '0;
              state <= S_ROUND;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          marker_done <= 1'b1;
          if (pos == 6'd55) len_go <= 1'b1;
          if (pos == 6'd63) begin
            for (int i = 0; i < 8; i++) v[i] <= hash[i];
            rnd   <= '0;
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (rnd >= 6'd16) w[rnd[3:0]] <= wi;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
          // A block that carried the length finishes the message; a final
          // request whose padding is not done yet goes on padding.
          priority if (!pad_active) begin
            state <= S_IDLE;
          end else if (len_go) begin
            oidx  <= '0;
            state <= S_OUT;
          end else begin
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state      <= S_IDLE;
              len        <= '0;
              pad_active <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                hash[i] <= sha256_pkg::INIT_HASH[32*(7-i) +: 32];
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ design/sha256_checker.sv @@
// Port-level checker for the SHA-256 message hasher, bound into the hasher module.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sha256_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] word_index,
  input logic       last_word
);
  `CHK_ALWAYS(a_no_overlap, clk, rst, !(in_ready && out_valid), "input ready while digest shown")
  `CHK_ALWAYS(a_last, clk, rst, out_valid |-> (last_word == (word_index == 3'd7)), "last_word mismatch")
  `CHK_ALWAYS(a_step, clk, rst, (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1), "digest word skipped")
  `CHK_RAW(a_reset, clk, rst |=> !out_valid, "digest shown after reset")
endmodule

bind sha256_message_hasher sha256_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .word_index(word_index), .last_word(last_word));
